// ----- rtl/bf3_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and weight table function for the 3x3 bilateral filter
// no dependencies
package bf3_pkg;

    localparam int MAX_LINE_PIXELS_DEF  = 1024;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int WEIGHT_ENTRIES       = 66;
    localparam int PIX_W                = 24;
    localparam int CFG_W                = 16;

    localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FIDX,
        ST_FACC,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PASS,
        KIND_FILT
    } t_kind;

    typedef struct packed {
        logic       ready;
        logic       update;
        logic       idx;
        logic       acc;
        logic       div;
        logic       emit;
        logic [3:0] tap;
        logic [1:0] ch;
        logic [2:0] bit_sel;
    } t_cmd;

    typedef struct packed {
        logic  accept;
        t_kind kind;
        logic  out_free;
    } t_stat;

    // squared spatial distance of a window tap
    function automatic logic [1:0] tap_dist(input logic [3:0] k);
        logic [1:0] d;
        case (k)
            4'd4:                      d = 2'd0;
            4'd1, 4'd3, 4'd5, 4'd7:    d = 2'd1;
            default:                   d = 2'd2;
        endcase
        return d;
    endfunction

    // exp(-k) with fb fraction bits, evaluated at elaboration
    function automatic logic [63:0] weight_of(input int k, input int fb);
        logic [63:0] v;
        v = 64'd1 << 32;
        for (int i = 1; i <= k; i++) begin
            v = (v * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
        end
        return (v + (64'd1 << (31 - fb))) >> (32 - fb);
    endfunction

endpackage

// ----- rtl/bf3_ram.sv -----
`timescale 1ns / 1ps
// generic single-address ram with registered read
// no dependencies
module bf3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/bf3_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer for the 3x3 bilateral filter: item intake, tap loop, divider, output
// depends on bf3_pkg
module bf3_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bf3_pkg::t_stat i_stat,
    output bf3_pkg::t_cmd  o_cmd
);
    import bf3_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_tap, n_tap;
    logic [1:0] r_ch, n_ch;
    logic [2:0] r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tap   <= '0;
            r_ch    <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_ch    <= n_ch;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_ch    = r_ch;
        n_bit   = r_bit;
        o_cmd         = '0;
        o_cmd.tap     = r_tap;
        o_cmd.ch      = r_ch;
        o_cmd.bit_sel = r_bit;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_stat.accept) n_state = ST_READ;
            end
            ST_READ: begin
                o_cmd.update = 1'b1;
                unique case (i_stat.kind)
                    KIND_PASS: n_state = ST_EMIT;
                    KIND_FILT: begin
                        n_tap   = '0;
                        n_ch    = '0;
                        n_state = ST_FIDX;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_FIDX: begin
                o_cmd.idx = 1'b1;
                n_state   = ST_FACC;
            end
            ST_FACC: begin
                o_cmd.acc = 1'b1;
                if (r_tap == 4'd8) begin
                    n_bit   = 3'd7;
                    n_state = ST_DIV;
                end else begin
                    n_tap   = r_tap + 4'd1;
                    n_state = ST_FIDX;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (r_bit == 3'd0) begin
                    if (r_ch == 2'd2) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_tap   = '0;
                        n_state = ST_FIDX;
                    end
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ----- rtl/bf3_dp.sv -----
`timescale 1ns / 1ps
// datapath: config, position counters, line stores, window, tap mac, divider, output reg
// depends on bf3_pkg and bf3_ram
module bf3_dp #(
    parameter int MAX_LINE_PIXELS  = bf3_pkg::MAX_LINE_PIXELS_DEF,
    parameter int WEIGHT_FRAC_BITS = bf3_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [bf3_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      s_axis_tvalid,
    input  logic [bf3_pkg::PIX_W-1:0] s_axis_tdata,
    input  logic                      s_axis_tuser,
    output logic                      s_axis_tready,
    output logic                      m_axis_tvalid,
    output logic [bf3_pkg::PIX_W-1:0] m_axis_tdata,
    output logic                      m_axis_tuser,
    input  logic                      m_axis_tready,
    input  bf3_pkg::t_cmd              i_cmd,
    output bf3_pkg::t_stat             o_stat
);
    import bf3_pkg::*;

    localparam int AW = $clog2(MAX_LINE_PIXELS);
    localparam int CW = $clog2(MAX_LINE_PIXELS + 1);
    localparam int WW = WEIGHT_FRAC_BITS + 1;
    localparam int DW = WW + 4;
    localparam int NW = WW + 12;
    localparam int RW = 17;

    logic [10:0]       r_cfg_w;
    logic [15:0]       r_cfg_h;
    logic [CW-1:0]     r_col, r_c;
    logic [RW-1:0]     r_row, r_r;
    logic [PIX_W-1:0]  r_pix;
    logic [PIX_W-1:0]  r_win [9];
    logic [6:0]        r_idx;
    logic [7:0]        r_q;
    logic [NW-1:0]     r_num;
    logic [DW-1:0]     r_den;
    logic [7:0]        r_quo;
    logic [PIX_W-1:0]  r_res;
    logic              r_fe;
    logic [PIX_W-1:0]  r_m_data;
    logic              r_m_user;
    logic              r_m_valid;

    logic [WW-1:0]     w_tab [WEIGHT_ENTRIES];
    logic [CW-1:0]     w_eff, c_adj, c_inc;
    logic [15:0]       h_eff;
    logic [RW-1:0]     h_p1, r_adj;
    logic              accept;
    logic [AW-1:0]     ram_addr;
    logic [PIX_W-1:0]  up_rd, mid_rd;
    logic              emit_row_end, fe_now;
    logic [7:0]        p_ch, q_ch, d_ch;
    logic [15:0]       sq;
    logic [6:0]        idx_sum;
    logic [WW-1:0]     w_sel;
    logic [NW-1:0]     prod, trial;
    logic              take;
    logic [7:0]        quo_next;

    for (genvar g = 0; g < WEIGHT_ENTRIES; g++) begin : g_tab
        assign w_tab[g] = WW'(weight_of(g, WEIGHT_FRAC_BITS));
    end

    // effective frame geometry
    always_comb begin
        if (r_cfg_w < 11'd3) begin
            w_eff = CW'(3);
        end else if (32'(r_cfg_w) > MAX_LINE_PIXELS) begin
            w_eff = CW'(MAX_LINE_PIXELS);
        end else begin
            w_eff = CW'(r_cfg_w);
        end
        h_eff = (r_cfg_h < 16'd3) ? 16'd3 : r_cfg_h;
        h_p1  = RW'(h_eff) + RW'(1);
    end

    // position of the incoming item
    always_comb begin
        c_adj = r_col;
        r_adj = r_row;
        if (r_col >= w_eff) begin
            c_adj = '0;
            r_adj = r_row + RW'(1);
        end
        if (r_adj > h_p1 || (r_adj == h_p1 && c_adj != '0)) begin
            c_adj = '0;
            r_adj = '0;
        end
    end

    assign s_axis_tready = i_cmd.ready;
    assign accept        = s_axis_tvalid & i_cmd.ready;
    assign ram_addr      = accept ? c_adj[AW-1:0] : r_c[AW-1:0];

    bf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_PIXELS)) u_upper (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_addr  (ram_addr),
        .i_wdata (mid_rd),
        .o_rdata (up_rd)
    );

    bf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_PIXELS)) u_middle (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_addr  (ram_addr),
        .i_wdata (r_pix),
        .o_rdata (mid_rd)
    );

    // what the stored item produces
    always_comb begin
        o_stat.accept   = accept;
        o_stat.out_free = ~r_m_valid | m_axis_tready;
        o_stat.kind     = KIND_NONE;
        emit_row_end    = 1'b0;
        fe_now          = 1'b0;
        if (r_c == '0) begin
            if (r_r >= RW'(2)) begin
                emit_row_end = 1'b1;
                o_stat.kind  = KIND_PASS;
                fe_now       = (r_r == h_p1);
            end
        end else if (r_r >= RW'(1) && r_r <= RW'(h_eff)) begin
            if (r_c == CW'(1) || r_r == RW'(1) || r_r == RW'(h_eff)) begin
                o_stat.kind = KIND_PASS;
            end else begin
                o_stat.kind = KIND_FILT;
            end
        end
        c_inc = r_c + CW'(1);
    end

    // tap weight index, multiply-accumulate and divider step
    always_comb begin
        case (i_cmd.ch)
            2'd1:    begin p_ch = r_win[4][15:8];  q_ch = r_win[i_cmd.tap][15:8];  end
            2'd2:    begin p_ch = r_win[4][23:16]; q_ch = r_win[i_cmd.tap][23:16]; end
            default: begin p_ch = r_win[4][7:0];   q_ch = r_win[i_cmd.tap][7:0];   end
        endcase
        d_ch    = (p_ch > q_ch) ? p_ch - q_ch : q_ch - p_ch;
        sq      = d_ch * d_ch;
        idx_sum = 7'(tap_dist(i_cmd.tap)) + 7'(sq[15:10]);
        w_sel   = w_tab[(r_idx < 7'(WEIGHT_ENTRIES)) ? r_idx : 7'(WEIGHT_ENTRIES - 1)];
        prod    = NW'(w_sel) * NW'(r_q);
        trial   = NW'(r_den) << i_cmd.bit_sel;
        take    = (r_num >= trial);
        quo_next = r_quo;
        quo_next[i_cmd.bit_sel] = take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= 11'd640;
            r_cfg_h   <= 16'd480;
            r_col     <= '0;
            r_row     <= '0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH:  r_cfg_w <= i_cfg_data[10:0];
                    CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_c   <= c_adj;
                r_r   <= r_adj;
                r_pix <= s_axis_tuser ? '0 : s_axis_tdata;
            end
            if (i_cmd.update) begin
                for (int row = 0; row < 3; row++) begin
                    r_win[row*3]     <= r_win[row*3+1];
                    r_win[row*3+1]   <= r_win[row*3+2];
                end
                r_win[2] <= up_rd;
                r_win[5] <= mid_rd;
                r_win[8] <= r_pix;
                // both pass cases deliver the old right middle tap
                r_res <= r_win[5];
                r_fe  <= emit_row_end & fe_now;
                if (fe_now && emit_row_end) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (c_inc >= w_eff) begin
                    r_col <= '0;
                    r_row <= r_r + RW'(1);
                end else begin
                    r_col <= c_inc;
                    r_row <= r_r;
                end
            end
            if (i_cmd.idx) begin
                r_idx <= idx_sum;
                r_q   <= q_ch;
            end
            if (i_cmd.acc) begin
                if (i_cmd.tap == 4'd0) begin
                    r_num <= prod;
                    r_den <= DW'(w_sel);
                end else begin
                    r_num <= r_num + prod;
                    r_den <= r_den + DW'(w_sel);
                end
            end
            if (i_cmd.div) begin
                if (take) r_num <= r_num - trial;
                r_quo <= quo_next;
                if (i_cmd.bit_sel == 3'd0) begin
                    case (i_cmd.ch)
                        2'd1:    r_res[15:8]  <= quo_next;
                        2'd2:    r_res[23:16] <= quo_next;
                        default: r_res[7:0]   <= quo_next;
                    endcase
                end
            end
            if (i_cmd.emit) begin
                r_m_valid <= 1'b1;
                r_m_data  <= r_res;
                r_m_user  <= r_fe;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
endmodule

// ----- rtl/bilateral_filter_3x3_rgb.sv -----
`timescale 1ns / 1ps
// Streaming 3x3 bilateral filter for 24-bit RGB pixels in raster order. Each pixel leaves
// one line and one pixel after it entered; border pixels pass through, inner pixels are
// filtered per channel with range and distance weights. After the last pixel of a frame,
// send image_width + 1 pad items to drain it. A new item is accepted only after the last
// is done. A filtered pixel goes through the window update, then for each channel the
// single shared tap multiply-accumulate (9 taps per channel) and the bit-serial divider,
// then the hand-off to the output register; a passed-through pixel skips taps and divider.
// The output register holds a result until taken, and the next item is accepted meanwhile;
// a further result waits until it is taken. Depends on bf3_pkg, bf3_ctrl, bf3_dp, bf3_ram.
module bilateral_filter_3x3_rgb #(
    parameter int MAX_LINE_PIXELS  = bf3_pkg::MAX_LINE_PIXELS_DEF,
    parameter int WEIGHT_FRAC_BITS = bf3_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [bf3_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [bf3_pkg::PIX_W-1:0] s_axis_tdata,  // in_blue, in_green, in_red
    input  logic                      s_axis_tuser,  // pad_item
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [bf3_pkg::PIX_W-1:0] m_axis_tdata,  // out_blue, out_green, out_red
    output logic                      m_axis_tuser   // frame_end
);
    import bf3_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bf3_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bf3_dp #(
        .MAX_LINE_PIXELS  (MAX_LINE_PIXELS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tready (m_axis_tready),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );
endmodule
